### hdl/appm_pkg.sv
package appm_pkg;

    // Width of the pulse, period and gate counters.
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Field widths of the fixed port fields.
    localparam int DIV_WIDTH  = 8;
    localparam int GATE_WIDTH = 16;
    localparam int CFG_WIDTH  = 16;
    localparam int ADDR_WIDTH = 2;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_BITS   = 4;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = 3 + 4 * COUNT_WIDTH;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    // Configuration register indexes.
    localparam logic [ADDR_WIDTH-1:0] REG_COUNT_MODE  = 2'd0;
    localparam logic [ADDR_WIDTH-1:0] REG_GATE_TICKS  = 2'd1;
    localparam logic [ADDR_WIDTH-1:0] REG_TICK_DIVIDE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic                  MODE_RESET   = 1'b0;
    localparam logic [GATE_WIDTH-1:0] GATE_RESET   = 16'd10000;
    localparam logic [DIV_WIDTH-1:0]  DIVIDE_RESET = 8'd100;

    // Measurement modes.
    localparam logic MODE_PERIOD = 1'b0;
    localparam logic MODE_GATED  = 1'b1;

    // One input item: one tick of the sampled pin.
    typedef struct packed {
        logic pin_level;
        logic clear_live;
        logic clear_log;
        logic clear_extreme;
    } item_t;

    // One result item.
    typedef struct packed {
        logic                   slow_tick;
        logic                   edge_seen;
        logic                   measure_valid;
        logic [COUNT_WIDTH-1:0] measured_value;
        logic [COUNT_WIDTH-1:0] extreme_value;
        logic [COUNT_WIDTH-1:0] live_pulses;
        logic [COUNT_WIDTH-1:0] log_pulses;
    } result_t;

    // Handshake control between the input stage and the meter.
    typedef struct packed {
        logic step;
        logic out_free;
    } flow_t;

endpackage

### hdl/anemometer_pulse_period_meter_top.sv
// Path: an input item accepted into the input register moves on to the result register
// once that register has room, and the result register offers it as a result item.
// Throughput: one item per cycle while the sink takes results; the tick update is one pass
// between input and result registers; the input stalls only while both are full.
// Reset: synchronous, active low on aresetn; counters clear, the extreme tracker
// is set to empty (all ones) and the configuration returns to its defaults.
module anemometer_pulse_period_meter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: pin_level, clear_live, clear_log, clear_extreme.
    input  logic [8*appm_pkg::IN_BYTES-1:0]   s_tdata,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: slow_tick, edge_seen, measure_valid, measured_value,
    // extreme_value, live_pulses, log_pulses.
    output logic [8*appm_pkg::OUT_BYTES-1:0]  m_tdata,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [appm_pkg::ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [appm_pkg::CFG_WIDTH-1:0]    cfg_wdata
);
    import appm_pkg::*;

    item_t   s_item;
    item_t   item;
    flow_t   flow;
    result_t result;
    result_t result_reg;
    logic    m_valid_reg;
    logic    out_free;

    // Unpack the input item.
    assign s_item.pin_level     = s_tdata[0];
    assign s_item.clear_live    = s_tdata[1];
    assign s_item.clear_log     = s_tdata[2];
    assign s_item.clear_extreme = s_tdata[3];

    assign out_free = !m_valid_reg || m_tready;

    appm_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_item   (s_item),
        .out_free (out_free),
        .flow     (flow),
        .item     (item)
    );

    appm_meter u_meter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .flow      (flow),
        .item      (item),
        .result    (result)
    );

    // Result register: holds one item until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (flow.out_free) begin
            m_valid_reg <= flow.step;
        end
    end

    always_ff @(posedge aclk) begin
        if (flow.step) begin
            result_reg <= result;
        end
    end

    // Pack the result item.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8*OUT_BYTES-OUT_BITS){1'b0}},
                       result_reg.log_pulses,
                       result_reg.live_pulses,
                       result_reg.extreme_value,
                       result_reg.measured_value,
                       result_reg.measure_valid,
                       result_reg.edge_seen,
                       result_reg.slow_tick};

endmodule

### hdl/appm_in_reg.sv
module appm_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  appm_pkg::item_t s_item,
    input  logic          out_free,
    output appm_pkg::flow_t flow,
    output appm_pkg::item_t item
);
    import appm_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  step;

    // The held item moves on whenever the result register has room.
    assign step    = valid_reg && out_free;
    assign s_ready = !valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign flow.step     = step;
    assign flow.out_free = out_free;
    assign item          = item_reg;

endmodule

### hdl/appm_meter.sv
module appm_meter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [appm_pkg::ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [appm_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    input  appm_pkg::flow_t                  flow,
    input  appm_pkg::item_t                  item,
    output appm_pkg::result_t                result
);
    import appm_pkg::*;

    // Configuration registers.
    logic                  count_mode_reg;
    logic [GATE_WIDTH-1:0] gate_ticks_reg;
    logic [DIV_WIDTH-1:0]  tick_divide_reg;

    // Measurement state.
    logic [DIV_WIDTH-1:0]   divider_count_reg, divider_count_next;
    logic [GATE_WIDTH-1:0]  gate_count_reg, gate_count_next;
    logic                   previous_level_reg;
    logic                   timing_active_reg, timing_active_next;
    logic [COUNT_WIDTH-1:0] interval_count_reg, interval_count_next;
    logic [COUNT_WIDTH-1:0] gated_edges_reg, gated_edges_next;
    logic [COUNT_WIDTH-1:0] published_value_reg, published_value_next;
    logic [COUNT_WIDTH-1:0] extreme_store_reg, extreme_store_next;
    logic [COUNT_WIDTH-1:0] live_store_reg, live_store_next;
    logic [COUNT_WIDTH-1:0] log_store_reg, log_store_next;

    logic                   slow, edge_det, valid;
    logic [DIV_WIDTH-1:0]   div_inc;
    logic [GATE_WIDTH-1:0]  gate_inc;
    logic [COUNT_WIDTH-1:0] live_clr, log_clr, extreme_clr;
    logic [COUNT_WIDTH-1:0] edges_inc, interval_inc;

    // Configuration writes; values are truncated to the register width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_mode_reg  <= MODE_RESET;
            gate_ticks_reg  <= GATE_RESET;
            tick_divide_reg <= DIVIDE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COUNT_MODE:  count_mode_reg  <= cfg_wdata[0];
                REG_GATE_TICKS:  gate_ticks_reg  <= cfg_wdata[GATE_WIDTH-1:0];
                REG_TICK_DIVIDE: tick_divide_reg <= cfg_wdata[DIV_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // One tick of update logic for the item held in the input register.
    always_comb begin
        // Clears take effect before this tick's own counting.
        live_clr    = item.clear_live    ? '0        : live_store_reg;
        log_clr     = item.clear_log     ? '0        : log_store_reg;
        extreme_clr = item.clear_extreme ? COUNT_MAX : extreme_store_reg;

        // Slow-activity divider.
        div_inc            = divider_count_reg + DIV_WIDTH'(1);
        slow               = (div_inc == tick_divide_reg);
        divider_count_next = slow ? '0 : div_inc;

        // Falling edge and pulse counters.
        edge_det        = previous_level_reg && !item.pin_level;
        live_store_next = live_clr + {{(COUNT_WIDTH-1){1'b0}}, edge_det};
        log_store_next  = log_clr  + {{(COUNT_WIDTH-1){1'b0}}, edge_det};

        edges_inc    = gated_edges_reg + {{(COUNT_WIDTH-1){1'b0}}, edge_det};
        gate_inc     = gate_count_reg + GATE_WIDTH'(1);
        interval_inc = (timing_active_reg && interval_count_reg != COUNT_MAX) ?
                       interval_count_reg + COUNT_WIDTH'(1) : interval_count_reg;

        valid                = 1'b0;
        gate_count_next      = gate_count_reg;
        gated_edges_next     = gated_edges_reg;
        timing_active_next   = timing_active_reg;
        interval_count_next  = interval_count_reg;
        published_value_next = published_value_reg;
        extreme_store_next   = extreme_clr;

        if (count_mode_reg == MODE_GATED) begin
            // Gated mode: an edge in the closing tick belongs to that gate.
            if (gate_inc == gate_ticks_reg) begin
                gate_count_next      = '0;
                gated_edges_next     = '0;
                published_value_next = edges_inc;
                valid                = 1'b1;
                if (edges_inc > extreme_clr || extreme_clr == COUNT_MAX) begin
                    extreme_store_next = edges_inc;
                end
            end else begin
                gate_count_next  = gate_inc;
                gated_edges_next = edges_inc;
            end
        end else begin
            // Period mode: the first edge only starts the timer.
            interval_count_next = interval_inc;
            if (edge_det) begin
                if (timing_active_reg) begin
                    published_value_next = interval_inc;
                    valid                = 1'b1;
                    if (interval_inc < extreme_clr) begin
                        extreme_store_next = interval_inc;
                    end
                end
                interval_count_next = '0;
                timing_active_next  = 1'b1;
            end
        end
    end

    // State advances once per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_count_reg   <= '0;
            gate_count_reg      <= '0;
            previous_level_reg  <= 1'b0;
            timing_active_reg   <= 1'b0;
            interval_count_reg  <= '0;
            gated_edges_reg     <= '0;
            published_value_reg <= '0;
            extreme_store_reg   <= COUNT_MAX;
            live_store_reg      <= '0;
            log_store_reg       <= '0;
        end else if (flow.step) begin
            divider_count_reg   <= divider_count_next;
            gate_count_reg      <= gate_count_next;
            previous_level_reg  <= item.pin_level;
            timing_active_reg   <= timing_active_next;
            interval_count_reg  <= interval_count_next;
            gated_edges_reg     <= gated_edges_next;
            published_value_reg <= published_value_next;
            extreme_store_reg   <= extreme_store_next;
            live_store_reg      <= live_store_next;
            log_store_reg       <= log_store_next;
        end
    end

    assign result.slow_tick      = slow;
    assign result.edge_seen      = edge_det;
    assign result.measure_valid  = valid;
    assign result.measured_value = published_value_next;
    assign result.extreme_value  = extreme_store_next;
    assign result.live_pulses    = live_store_next;
    assign result.log_pulses     = log_store_next;

endmodule

### tb/anemometer_pulse_period_meter_top_tb.sv
`timescale 1ns / 100ps

module anemometer_pulse_period_meter_top_tb;

    import appm_pkg::*;

    localparam int IN_W        = 8 * IN_BYTES;
    localparam int OUT_W       = 8 * OUT_BYTES;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 300;
    localparam int STEADY_RUN  = 200;
    localparam int RANDOM_GOAL = 1050;

    // One tick as it sits in s_tdata, pin_level in bit 0.
    typedef struct packed {
        logic clear_extreme;
        logic clear_log;
        logic clear_live;
        logic pin_level;
    } tick_t;

    // One result as it sits in m_tdata, slow_tick in bit 0.
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] log_pulses;
        logic [COUNT_WIDTH-1:0] live_pulses;
        logic [COUNT_WIDTH-1:0] extreme_value;
        logic [COUNT_WIDTH-1:0] measured_value;
        logic                   measure_valid;
        logic                   edge_seen;
        logic                   slow_tick;
    } meter_out_t;

    typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

    // One line of the directed plan: a tick, or a register write.
    typedef struct {
        row_kind_t             kind;
        logic [ADDR_WIDTH-1:0] idx;
        logic [CFG_WIDTH-1:0]  val;
        tick_t                 t;
        logic                  pinned;
        meter_out_t            want;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [ADDR_WIDTH-1:0] cfg_addr  = '0;
    logic [CFG_WIDTH-1:0]  cfg_wdata = '0;

    // Fixed expectation that travels with the item being offered.
    logic       row_pinned = 1'b0;
    meter_out_t row_want   = '0;

    // Meter model: configuration.
    logic                   cfg_mode   = MODE_RESET;
    logic [GATE_WIDTH-1:0]  cfg_gate   = GATE_RESET;
    logic [DIV_WIDTH-1:0]   cfg_divide = DIVIDE_RESET;

    // Meter model: state.
    logic [DIV_WIDTH-1:0]   div_cnt      = '0;
    logic [GATE_WIDTH-1:0]  gate_cnt     = '0;
    logic                   last_pin     = 1'b0;
    logic                   timing_on    = 1'b0;
    logic [COUNT_WIDTH-1:0] period_cnt   = '0;
    logic [COUNT_WIDTH-1:0] gate_edges   = '0;
    logic [COUNT_WIDTH-1:0] shown_value  = '0;
    logic [COUNT_WIDTH-1:0] extreme_hold = COUNT_MAX;
    logic [COUNT_WIDTH-1:0] live_cnt     = '0;
    logic [COUNT_WIDTH-1:0] log_cnt      = '0;

    meter_out_t expected_readings[$];
    plan_row_t  plan[$];

    int errors        = 0;
    int ticks_taken   = 0;
    int readings_seen = 0;
    int publishes     = 0;
    int slow_ticks    = 0;
    int falls_seen    = 0;
    int tx_idle_pct   = 37;
    int rx_idle_pct   = 37;
    int hold_asked    = 0;
    int hold_served   = 0;
    int stall_left    = 0;
    int cycles        = 0;

    // Pulse shape for the random ticks.
    logic wave_level = 1'b0;
    int   wave_left  = 0;

    anemometer_pulse_period_meter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Advance the meter model by one tick and return what it reports.
    function automatic meter_out_t meter_tick(tick_t t);
        meter_out_t r;
        logic       fall;
        r = '0;
        if (t.clear_live) begin
            live_cnt = '0;
        end
        if (t.clear_log) begin
            log_cnt = '0;
        end
        if (t.clear_extreme) begin
            extreme_hold = COUNT_MAX;
        end
        div_cnt = div_cnt + DIV_WIDTH'(1);
        if (div_cnt == cfg_divide) begin
            div_cnt     = '0;
            r.slow_tick = 1'b1;
        end
        fall = last_pin && !t.pin_level;
        if (fall) begin
            live_cnt = live_cnt + COUNT_WIDTH'(1);
            log_cnt  = log_cnt + COUNT_WIDTH'(1);
        end
        if (cfg_mode == MODE_GATED) begin
            // Edges in the closing tick still belong to the gate.
            if (fall) begin
                gate_edges = gate_edges + COUNT_WIDTH'(1);
            end
            gate_cnt = gate_cnt + GATE_WIDTH'(1);
            if (gate_cnt == cfg_gate) begin
                gate_cnt        = '0;
                shown_value     = gate_edges;
                gate_edges      = '0;
                r.measure_valid = 1'b1;
                if (shown_value > extreme_hold || extreme_hold == COUNT_MAX) begin
                    extreme_hold = shown_value;
                end
            end
        end else begin
            // The period counter sticks at all ones; the first edge only arms it.
            if (timing_on && period_cnt != COUNT_MAX) begin
                period_cnt = period_cnt + COUNT_WIDTH'(1);
            end
            if (fall) begin
                if (timing_on) begin
                    shown_value     = period_cnt;
                    r.measure_valid = 1'b1;
                    if (shown_value < extreme_hold) begin
                        extreme_hold = shown_value;
                    end
                end
                period_cnt = '0;
                timing_on  = 1'b1;
            end
        end
        last_pin         = t.pin_level;
        r.edge_seen      = fall;
        r.measured_value = shown_value;
        r.extreme_value  = extreme_hold;
        r.live_pulses    = live_cnt;
        r.log_pulses     = log_cnt;
        return r;
    endfunction

    function automatic tick_t tk(logic pin, logic c_live, logic c_log, logic c_ext);
        tick_t t;
        t.pin_level     = pin;
        t.clear_live    = c_live;
        t.clear_log     = c_log;
        t.clear_extreme = c_ext;
        return t;
    endfunction

    function automatic meter_out_t reading(logic slow, logic fall, logic valid,
                                           logic [15:0] meas, logic [15:0] ext,
                                           logic [15:0] live, logic [15:0] logged);
        meter_out_t r;
        r.slow_tick      = slow;
        r.edge_seen      = fall;
        r.measure_valid  = valid;
        r.measured_value = meas;
        r.extreme_value  = ext;
        r.live_pulses    = live;
        r.log_pulses     = logged;
        return r;
    endfunction

    function automatic plan_row_t tick_row(tick_t t);
        plan_row_t p;
        p        = '{kind: ROW_TICK, default: '0};
        p.t      = t;
        return p;
    endfunction

    function automatic plan_row_t pinned_row(tick_t t, meter_out_t want);
        plan_row_t p;
        p        = tick_row(t);
        p.pinned = 1'b1;
        p.want   = want;
        return p;
    endfunction

    function automatic plan_row_t reg_row(logic [ADDR_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
        plan_row_t p;
        p      = '{kind: ROW_REG, default: '0};
        p.idx  = idx;
        p.val  = val;
        return p;
    endfunction

    // Next random tick: mostly clean pulses of random width, some glitches and clears.
    function automatic tick_t next_tick();
        tick_t t;
        if (wave_left == 0) begin
            wave_level = ~wave_level;
            wave_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                     : $urandom_range(1, 8);
        end
        wave_left       = wave_left - 1;
        t.pin_level     = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : wave_level;
        t.clear_live    = ($urandom_range(0, 39) == 0);
        t.clear_log     = ($urandom_range(0, 39) == 0);
        t.clear_extreme = ($urandom_range(0, 29) == 0);
        return t;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors = errors + 1;
            if (errors <= 10) begin
                $display("reading %0d: %s expected %h, got %h", readings_seen, name, want, got);
            end
        end
    endtask

    // Offer one tick and hold it until it is taken; then maybe pause.
    task automatic send_tick(tick_t t, logic pinned, meter_out_t want);
        s_tdata    <= {{(IN_W - 4){1'b0}}, t};
        row_pinned <= pinned;
        row_want   <= want;
        s_tvalid   <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every reading is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Register write; the model takes the value along with the block.
    task automatic write_reg(logic [ADDR_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COUNT_MODE:  cfg_mode   = val[0];
            REG_GATE_TICKS:  cfg_gate   = val[GATE_WIDTH-1:0];
            REG_TICK_DIVIDE: cfg_divide = val[DIV_WIDTH-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Receiver: random back-pressure, plus long hold-offs on request.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            stall_left  <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Predict on every accepted tick, check every accepted reading.
    always @(posedge aclk) begin
        meter_out_t want;
        meter_out_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = meter_tick(tick_t'(s_tdata[3:0]));
                if (row_pinned) begin
                    want = row_want;
                end
                ticks_taken = ticks_taken + 1;
                expected_readings.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = meter_out_t'(m_tdata[OUT_BITS-1:0]);
                readings_seen = readings_seen + 1;
                if (expected_readings.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10) begin
                        $display("reading %0d arrived with nothing expected: %h",
                                 readings_seen, got);
                    end
                end else begin
                    want = expected_readings.pop_front();
                    check_field("slow_tick", 16'(want.slow_tick), 16'(got.slow_tick));
                    check_field("edge_seen", 16'(want.edge_seen), 16'(got.edge_seen));
                    check_field("measure_valid", 16'(want.measure_valid),
                                16'(got.measure_valid));
                    check_field("measured_value", want.measured_value, got.measured_value);
                    check_field("extreme_value", want.extreme_value, got.extreme_value);
                    check_field("live_pulses", want.live_pulses, got.live_pulses);
                    check_field("log_pulses", want.log_pulses, got.log_pulses);
                    publishes  = publishes + want.measure_valid;
                    slow_ticks = slow_ticks + want.slow_tick;
                    falls_seen = falls_seen + want.edge_seen;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles = cycles + 1;
        end
        $display("anemometer_pulse_period_meter_top_tb: errors");
        $finish;
    end

    initial begin
        int                   random_ticks;
        int                   phases;
        int                   burst;
        int                   sel;
        logic [GATE_WIDTH-1:0] g;
        logic [DIV_WIDTH-1:0]  d;

        random_ticks = 0;
        phases       = 0;

        // Directed plan. Defaults after reset: period mode, divide 100.
        plan.push_back(pinned_row(tk(0, 0, 0, 0), reading(0, 0, 0, 0, 16'hFFFF, 0, 0)));
        plan.push_back(pinned_row(tk(1, 0, 0, 0), reading(0, 0, 0, 0, 16'hFFFF, 0, 0)));
        plan.push_back(pinned_row(tk(0, 0, 0, 0), reading(0, 1, 0, 0, 16'hFFFF, 1, 1)));
        plan.push_back(pinned_row(tk(1, 0, 0, 0), reading(0, 0, 0, 0, 16'hFFFF, 1, 1)));
        plan.push_back(pinned_row(tk(0, 0, 0, 0), reading(0, 1, 1, 2, 2, 2, 2)));
        plan.push_back(pinned_row(tk(0, 1, 1, 1), reading(0, 0, 0, 2, 16'hFFFF, 0, 0)));
        plan.push_back(tick_row(tk(1, 1, 0, 0)));
        // Edge in the same tick as the clears counts after them.
        plan.push_back(tick_row(tk(0, 1, 1, 0)));
        plan.push_back(reg_row(REG_TICK_DIVIDE, 16'd1));
        plan.push_back(tick_row(tk(1, 0, 0, 0)));
        plan.push_back(tick_row(tk(0, 0, 0, 1)));
        // Gated mode with the shortest gate: edge in the closing tick.
        plan.push_back(reg_row(REG_COUNT_MODE, 16'(MODE_GATED)));
        plan.push_back(reg_row(REG_GATE_TICKS, 16'd1));
        plan.push_back(tick_row(tk(1, 0, 0, 0)));
        plan.push_back(tick_row(tk(0, 0, 0, 0)));
        plan.push_back(tick_row(tk(1, 0, 0, 1)));
        plan.push_back(tick_row(tk(0, 0, 0, 0)));
        plan.push_back(reg_row(REG_GATE_TICKS, 16'hFFFF));
        plan.push_back(reg_row(REG_TICK_DIVIDE, 16'd255));
        plan.push_back(tick_row(tk(1, 0, 0, 0)));
        plan.push_back(tick_row(tk(0, 0, 0, 0)));
        plan.push_back(tick_row(tk(1, 1, 1, 1)));
        // Back to period mode; the gated machine keeps its count.
        plan.push_back(reg_row(REG_COUNT_MODE, 16'(MODE_PERIOD)));
        plan.push_back(reg_row(REG_GATE_TICKS, 16'd8));
        plan.push_back(tick_row(tk(0, 0, 0, 0)));
        plan.push_back(tick_row(tk(1, 0, 0, 0)));
        plan.push_back(tick_row(tk(0, 0, 0, 0)));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                drain();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_tick(plan[i].t, plan[i].pinned, plan[i].want);
            end
        end

        // Output held off while ticks keep coming, so the input stalls.
        drain();
        write_reg(REG_COUNT_MODE, 16'(MODE_PERIOD));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_asked = hold_asked + 1;
        repeat (80) send_tick(next_tick(), 1'b0, '0);

        // A steady stretch with no idling on either side.
        repeat (STEADY_RUN) send_tick(next_tick(), 1'b0, '0);
        tx_idle_pct = 37;
        rx_idle_pct = 37;

        // Random phases, each with fresh register settings.
        while (random_ticks < RANDOM_GOAL) begin
            drain();
            phases = phases + 1;
            write_reg(REG_COUNT_MODE, 16'($urandom_range(0, 1)));
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                g = 16'hFFFF;
            end else if (sel == 1 && gate_cnt == 0) begin
                g = 16'd1;
            end else if (gate_cnt < 16'd65400) begin
                // Keep the gate ahead of the running count so it closes soon.
                g = gate_cnt + 16'($urandom_range(1, 60));
            end else begin
                g = 16'($urandom_range(1, 60));
            end
            write_reg(REG_GATE_TICKS, g);
            sel = $urandom_range(0, 9);
            d   = (sel == 0) ? 8'd1 : (sel == 1) ? 8'd255 : 8'($urandom_range(2, 254));
            write_reg(REG_TICK_DIVIDE, 16'(d));
            burst = $urandom_range(30, 120);
            repeat (burst) send_tick(next_tick(), 1'b0, '0);
            random_ticks = random_ticks + burst;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (expected_readings.size() != 0) begin
            errors = errors + expected_readings.size();
            $display("%0d readings never arrived", expected_readings.size());
        end

        $display("Ran %0d ticks through %0d register phases: %0d readings, %0d published,",
                 ticks_taken, phases, readings_seen, publishes);
        $display("%0d falling edges and %0d slow ticks, incl. a long stall and a gapless run.",
                 falls_seen, slow_ticks);
        if (errors == 0) begin
            $display("anemometer_pulse_period_meter_top_tb: clean");
        end else begin
            $display("anemometer_pulse_period_meter_top_tb: errors");
        end
        $finish;
    end

endmodule
